@@ rtl/krce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krce_pkg
// Shared types, widths and event codes for the key report change events block.
// ----------------------------------------------------------------------------
package krce_pkg;

    localparam int KEY_SLOTS     = 6;
    localparam int NUM_IN_FIELDS = 6;
    localparam int CODE_W        = 16;
    localparam int KIND_W        = 2;

    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int CNT_W = $clog2(KEY_SLOTS + 1);
    localparam int EVT_W = $clog2(2 * KEY_SLOTS + 1);

    localparam logic [KIND_W-1:0] KIND_MOD_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESS    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MOD_UP   = 2'd3;

    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        t_code code_slot0;
        t_code code_slot1;
        t_code code_slot2;
        t_code code_slot3;
        t_code code_slot4;
        t_code code_slot5;
    } t_report;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        t_code             key_code;
        logic              last_event;
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event evt;
    } t_evt_req;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_res;

endpackage

@@ rtl/krce_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krce_cmp
// Shared key code comparator, used by both the sort and the merge passes.
// ----------------------------------------------------------------------------
module krce_cmp (
    input  krce_pkg::t_code    i_a,
    input  krce_pkg::t_code    i_b,
    output krce_pkg::t_cmp_res o_res
);
    import krce_pkg::*;

    assign o_res.eq = (i_a == i_b);
    assign o_res.lt = (i_a < i_b);

endmodule

@@ rtl/krce_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krce_out
// Output register for event beats; frees the sequencer from the sink.
// ----------------------------------------------------------------------------
module krce_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  krce_pkg::t_evt_req i_req,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output krce_pkg::t_event  o_event
);
    import krce_pkg::*;

    logic   r_valid;
    t_event r_event;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_event = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_req.valid) begin
            r_event <= i_req.evt;
        end
    end

endmodule

@@ rtl/krce_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krce_ctrl
// Sequencer: insertion sort of the report, merge against the held set,
// then emission of modifier, press and release events one per beat.
// ----------------------------------------------------------------------------
module krce_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  krce_pkg::t_report  i_report,
    output logic               o_idle,
    output krce_pkg::t_evt_req o_req,
    input  logic               i_free
);
    import krce_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SORT   = 3'd1;
    localparam logic [2:0] S_MERGE  = 3'd2;
    localparam logic [2:0] S_MODDN  = 3'd3;
    localparam logic [2:0] S_PRESS  = 3'd4;
    localparam logic [2:0] S_REL    = 3'd5;
    localparam logic [2:0] S_MODUP  = 3'd6;
    localparam logic [2:0] S_COMMIT = 3'd7;

    logic [2:0]           r_state, n_state;
    t_code                r_slot  [KEY_SLOTS];
    t_code                n_slot  [KEY_SLOTS];
    t_code                r_fresh [KEY_SLOTS];
    t_code                n_fresh [KEY_SLOTS];
    t_code                r_held  [KEY_SLOTS];
    t_code                n_held  [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] r_new, n_new;
    logic [KEY_SLOTS-1:0] r_gone, n_gone;
    logic [CNT_W-1:0]     r_si, n_si;
    logic [CNT_W-1:0]     r_j, n_j;
    logic [CNT_W-1:0]     r_a, n_a;
    logic [CNT_W-1:0]     r_b, n_b;
    logic [CNT_W-1:0]     r_fcnt, n_fcnt;
    logic [CNT_W-1:0]     r_hcnt, n_hcnt;
    logic [EVT_W-1:0]     r_left, n_left;

    t_code    in_codes [NUM_IN_FIELDS];
    t_code    slot_in  [KEY_SLOTS];
    t_code    cur_code;
    t_code    cmp_a, cmp_b;
    t_cmp_res cmp_res;
    logic     mod_dn, mod_up, fire;

    assign in_codes[0] = i_report.code_slot0;
    assign in_codes[1] = i_report.code_slot1;
    assign in_codes[2] = i_report.code_slot2;
    assign in_codes[3] = i_report.code_slot3;
    assign in_codes[4] = i_report.code_slot4;
    assign in_codes[5] = i_report.code_slot5;

    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
        if (g < NUM_IN_FIELDS) begin : g_used
            assign slot_in[g] = in_codes[g];
        end else begin : g_pad
            assign slot_in[g] = '0;
        end
    end

    assign o_idle   = (r_state == S_IDLE);
    assign cur_code = r_slot[r_si[IDX_W-1:0]];
    assign mod_dn   = (r_hcnt == '0) && (r_fcnt != '0);
    assign mod_up   = (r_hcnt != '0) && (r_fcnt == '0);
    assign fire     = o_req.valid && i_free;

    always_comb begin
        if (r_state == S_SORT) begin
            cmp_a = cur_code;
            cmp_b = r_fresh[r_j[IDX_W-1:0]];
        end else begin
            cmp_a = r_fresh[r_a[IDX_W-1:0]];
            cmp_b = r_held[r_b[IDX_W-1:0]];
        end
    end

    krce_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    // emission request, one event per beat
    always_comb begin
        o_req                = '0;
        o_req.evt.last_event = (r_left == EVT_W'(1));
        case (r_state)
            S_MODDN: begin
                o_req.valid          = mod_dn;
                o_req.evt.event_kind = KIND_MOD_DOWN;
            end
            S_PRESS: begin
                o_req.valid          = (r_a != r_fcnt) && r_new[r_a[IDX_W-1:0]];
                o_req.evt.event_kind = KIND_PRESS;
                o_req.evt.key_code   = r_fresh[r_a[IDX_W-1:0]];
            end
            S_REL: begin
                o_req.valid          = (r_b != r_hcnt) && r_gone[r_b[IDX_W-1:0]];
                o_req.evt.event_kind = KIND_RELEASE;
                o_req.evt.key_code   = r_held[r_b[IDX_W-1:0]];
            end
            S_MODUP: begin
                o_req.valid          = mod_up;
                o_req.evt.event_kind = KIND_MOD_UP;
            end
            default: begin
                o_req.valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_fresh = r_fresh;
        n_held  = r_held;
        n_new   = r_new;
        n_gone  = r_gone;
        n_si    = r_si;
        n_j     = r_j;
        n_a     = r_a;
        n_b     = r_b;
        n_fcnt  = r_fcnt;
        n_hcnt  = r_hcnt;
        n_left  = r_left;
        if (fire) begin
            n_left = r_left - EVT_W'(1);
        end
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_slot  = slot_in;
                    n_si    = '0;
                    n_j     = '0;
                    n_fcnt  = '0;
                    n_state = S_SORT;
                end
            end
            S_SORT: begin
                if (r_si == CNT_W'(KEY_SLOTS)) begin
                    n_a     = '0;
                    n_b     = '0;
                    n_new   = '0;
                    n_gone  = '0;
                    n_left  = '0;
                    n_state = S_MERGE;
                end else if (cur_code == '0) begin
                    n_si = r_si + CNT_W'(1);
                    n_j  = '0;
                end else if (r_j == r_fcnt) begin
                    n_fresh[r_fcnt[IDX_W-1:0]] = cur_code;
                    n_fcnt = r_fcnt + CNT_W'(1);
                    n_si   = r_si + CNT_W'(1);
                    n_j    = '0;
                end else if (cmp_res.eq) begin
                    // repeated code, one key
                    n_si = r_si + CNT_W'(1);
                    n_j  = '0;
                end else if (cmp_res.lt) begin
                    for (int k = 1; k < KEY_SLOTS; k++) begin
                        if (CNT_W'(k) > r_j) begin
                            n_fresh[k] = r_fresh[k-1];
                        end
                    end
                    n_fresh[r_j[IDX_W-1:0]] = cur_code;
                    n_fcnt = r_fcnt + CNT_W'(1);
                    n_si   = r_si + CNT_W'(1);
                    n_j    = '0;
                end else begin
                    n_j = r_j + CNT_W'(1);
                end
            end
            S_MERGE: begin
                if ((r_a == r_fcnt) && (r_b == r_hcnt)) begin
                    n_left = r_left + EVT_W'(mod_dn) + EVT_W'(mod_up);
                    n_a    = '0;
                    n_b    = '0;
                    if ((r_left == '0) && !mod_dn && !mod_up) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_state = S_MODDN;
                    end
                end else if (r_a == r_fcnt) begin
                    n_gone[r_b[IDX_W-1:0]] = 1'b1;
                    n_b    = r_b + CNT_W'(1);
                    n_left = r_left + EVT_W'(1);
                end else if (r_b == r_hcnt) begin
                    n_new[r_a[IDX_W-1:0]] = 1'b1;
                    n_a    = r_a + CNT_W'(1);
                    n_left = r_left + EVT_W'(1);
                end else if (cmp_res.eq) begin
                    n_a = r_a + CNT_W'(1);
                    n_b = r_b + CNT_W'(1);
                end else if (cmp_res.lt) begin
                    n_new[r_a[IDX_W-1:0]] = 1'b1;
                    n_a    = r_a + CNT_W'(1);
                    n_left = r_left + EVT_W'(1);
                end else begin
                    n_gone[r_b[IDX_W-1:0]] = 1'b1;
                    n_b    = r_b + CNT_W'(1);
                    n_left = r_left + EVT_W'(1);
                end
            end
            S_MODDN: begin
                if (!o_req.valid || i_free) begin
                    n_state = S_PRESS;
                end
            end
            S_PRESS: begin
                if (r_a == r_fcnt) begin
                    n_state = S_REL;
                end else if (!o_req.valid || i_free) begin
                    n_a = r_a + CNT_W'(1);
                end
            end
            S_REL: begin
                if (r_b == r_hcnt) begin
                    n_state = S_MODUP;
                end else if (!o_req.valid || i_free) begin
                    n_b = r_b + CNT_W'(1);
                end
            end
            S_MODUP: begin
                if (!o_req.valid || i_free) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                for (int k = 0; k < KEY_SLOTS; k++) begin
                    n_held[k] = (CNT_W'(k) < r_fcnt) ? r_fresh[k] : '0;
                end
                n_hcnt  = r_fcnt;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hcnt  <= '0;
            r_left  <= '0;
            for (int k = 0; k < KEY_SLOTS; k++) begin
                r_held[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_hcnt  <= n_hcnt;
            r_left  <= n_left;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_fresh <= n_fresh;
        r_new   <= n_new;
        r_gone  <= n_gone;
        r_si    <= n_si;
        r_j     <= n_j;
        r_a     <= n_a;
        r_b     <= n_b;
        r_fcnt  <= n_fcnt;
    end

    a_fcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_fcnt <= CNT_W'(KEY_SLOTS)))
        else $error("fresh set overflow");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_left == '0))
        else $error("events outstanding while idle");

    a_press_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req.valid && (r_state == S_PRESS)) |-> (o_req.evt.key_code != '0))
        else $error("press of empty code");

    a_merge_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> ((r_a <= r_fcnt) && (r_b <= r_hcnt)))
        else $error("merge pointer past end");

    a_last_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && o_req.evt.last_event) |=> (r_left == '0))
        else $error("events left after last beat");

endmodule

@@ rtl/key_report_change_events.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_report_change_events
// Turns keyboard reports into modifier, press and release event beats.
// ----------------------------------------------------------------------------
// One report is taken at a time; o_ready is high only while the sequencer idles.
// A report keeps the block busy through an insertion sort and a merge, both on one
// shared comparator, then through emission and commit; output stalls lengthen it.
// Events leave one per beat, and the next report is not taken until the previous
// one has been committed.
// Reset (synchronous, active low) empties the held key set and the output.
module key_report_change_events (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  krce_pkg::t_report i_report,
    output logic              o_valid,
    input  logic              i_ready,
    output krce_pkg::t_event  o_event
);
    import krce_pkg::*;

    t_evt_req req;
    logic     idle;
    logic     free;

    assign o_ready = idle;

    krce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_valid && idle),
        .i_report (i_report),
        .o_idle   (idle),
        .o_req    (req),
        .i_free   (free)
    );

    krce_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_free  (free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_event (o_event)
    );

endmodule
